@@ sv/apq_pkg.sv @@
package apq_pkg;

  // Input action codes
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_AGE    = 2'd2,
    ACT_PURGE  = 2'd3
  } action_e;

  // Widths fixed by the item formats
  localparam int PAYLOAD_W = 16;
  localparam int PRIO_W    = 8;
  localparam int COUNT_W   = 4;

  typedef struct packed {
    action_e                    action;
    logic [PAYLOAD_W-1:0]       new_payload;
    logic signed [PRIO_W-1:0]   new_priority;
    logic signed [PRIO_W-1:0]   new_patience;
  } in_item_t;

  typedef struct packed {
    logic                       head_valid;
    logic [PAYLOAD_W-1:0]       head_payload;
    logic signed [PRIO_W-1:0]   head_priority;
    logic signed [PRIO_W-1:0]   head_patience;
    logic [COUNT_W-1:0]         occupancy;
    logic                       dropped;
    logic [COUNT_W-1:0]         purged_count;
  } out_item_t;

  // One stored queue entry
  typedef struct packed {
    logic [PAYLOAD_W-1:0]       payload;
    logic signed [PRIO_W-1:0]   prio;
    logic signed [PRIO_W-1:0]   patience;
  } entry_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_PURGE = 1'b1
  } ctrl_state_e;

  typedef enum logic [2:0] {
    CMD_NONE        = 3'd0,
    CMD_INSERT      = 3'd1,
    CMD_REMOVE      = 3'd2,
    CMD_AGE         = 3'd3,
    CMD_PURGE_START = 3'd4,
    CMD_PURGE_STEP  = 3'd5
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   load_result;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic purge_last;
  } dp_status_t;

  localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};

  // Decrement, holding at the most negative value
  function automatic logic signed [PRIO_W-1:0] dec_sat(input logic signed [PRIO_W-1:0] v);
    logic signed [PRIO_W-1:0] r;
    r = (v == PRIO_MIN) ? v : PRIO_W'(v - PRIO_W'(1));
    return r;
  endfunction

endpackage

@@ sv/apq_ctrl.sv @@
module apq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  apq_pkg::action_e     action,
  input  logic                 result_stall,
  input  apq_pkg::dp_status_t  status,
  output logic                 item_stall,
  output logic                 result_valid,
  output apq_pkg::dp_cmd_t     cmd
);

  apq_pkg::ctrl_state_e state, state_next;
  logic result_valid_next;
  logic accept;

  // Take a new item only when idle and the output register is free or being drained
  assign item_stall = (state != apq_pkg::ST_IDLE) || (result_valid && result_stall);
  assign accept     = item_valid && !item_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      apq_pkg::ST_IDLE: begin
        if (accept && action == apq_pkg::ACT_PURGE && !status.count_zero) begin
          state_next = apq_pkg::ST_PURGE;
        end
      end
      apq_pkg::ST_PURGE: begin
        if (status.purge_last) begin
          state_next = apq_pkg::ST_IDLE;
        end
      end
      default: state_next = apq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op          = apq_pkg::CMD_NONE;
    cmd.load_result = 1'b0;
    unique case (state)
      apq_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (action)
            apq_pkg::ACT_INSERT: cmd.op = apq_pkg::CMD_INSERT;
            apq_pkg::ACT_REMOVE: cmd.op = apq_pkg::CMD_REMOVE;
            apq_pkg::ACT_AGE:    cmd.op = apq_pkg::CMD_AGE;
            apq_pkg::ACT_PURGE:  cmd.op = apq_pkg::CMD_PURGE_START;
            default:             cmd.op = apq_pkg::CMD_NONE;
          endcase
          cmd.load_result = (action != apq_pkg::ACT_PURGE) || status.count_zero;
        end
      end
      apq_pkg::ST_PURGE: begin
        cmd.op          = apq_pkg::CMD_PURGE_STEP;
        cmd.load_result = status.purge_last;
      end
      default: ;
    endcase
  end

  assign result_valid_next = cmd.load_result || (result_valid && result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= apq_pkg::ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

@@ sv/apq_datapath.sv @@
module apq_datapath #(
  parameter int DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  apq_pkg::dp_cmd_t     cmd,
  input  apq_pkg::in_item_t    item,
  output apq_pkg::dp_status_t  status,
  output apq_pkg::out_item_t   result
);

  localparam int CW = $clog2(DEPTH + 1);

  apq_pkg::entry_t slot [DEPTH];
  apq_pkg::entry_t slot_next [DEPTH];
  apq_pkg::entry_t from_below [DEPTH];
  apq_pkg::entry_t from_above [DEPTH];
  logic [DEPTH-1:0] le;
  logic [DEPTH-1:0] prev_le;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] remain, remain_next;
  logic [CW-1:0] kept, kept_next;
  logic [CW-1:0] wr_pos;
  logic          full;
  logic          head_keep;
  apq_pkg::entry_t    new_entry;
  apq_pkg::out_item_t res_next;

  assign full      = (count == CW'(DEPTH));
  assign head_keep = (slot[0].patience > 8'sd0);
  assign wr_pos    = CW'(remain + kept - CW'(1));
  assign new_entry = '{payload: item.new_payload, prio: item.new_priority,
                       patience: item.new_patience};

  assign status.count_zero = (count == '0);
  assign status.purge_last = (remain == CW'(1));

  // Neighbour taps and the insert position compare, one per slot
  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      le[j] = (CW'(j) < count) && (slot[j].prio <= item.new_priority);
    end
    prev_le[0]    = 1'b1;
    from_below[0] = slot[0];
    for (int j = 1; j < DEPTH; j++) begin
      prev_le[j]    = le[j-1];
      from_below[j] = slot[j-1];
    end
    for (int j = 0; j < DEPTH - 1; j++) begin
      from_above[j] = slot[j+1];
    end
    from_above[DEPTH-1] = slot[DEPTH-1];
  end

  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      slot_next[j] = slot[j];
    end
    count_next  = count;
    remain_next = remain;
    kept_next   = kept;
    res_next    = '0;
    res_next.occupancy = apq_pkg::COUNT_W'(count);
    unique case (cmd.op)
      apq_pkg::CMD_INSERT: begin
        if (full) begin
          res_next.dropped = 1'b1;
        end else begin
          for (int j = 0; j < DEPTH; j++) begin
            priority if (le[j]) begin
              slot_next[j] = slot[j];
            end else if (prev_le[j]) begin
              slot_next[j] = new_entry;
            end else begin
              slot_next[j] = from_below[j];
            end
          end
          count_next = CW'(count + CW'(1));
          res_next.occupancy = apq_pkg::COUNT_W'(count_next);
        end
      end
      apq_pkg::CMD_REMOVE: begin
        if (count != '0) begin
          for (int j = 0; j < DEPTH; j++) begin
            slot_next[j] = from_above[j];
          end
          count_next              = CW'(count - CW'(1));
          res_next.head_valid     = 1'b1;
          res_next.head_payload   = slot[0].payload;
          res_next.head_priority  = slot[0].prio;
          res_next.head_patience  = slot[0].patience;
          res_next.occupancy      = apq_pkg::COUNT_W'(count_next);
        end
      end
      apq_pkg::CMD_AGE: begin
        for (int j = 0; j < DEPTH; j++) begin
          slot_next[j].prio     = apq_pkg::dec_sat(slot[j].prio);
          slot_next[j].patience = apq_pkg::dec_sat(slot[j].patience);
        end
      end
      apq_pkg::CMD_PURGE_START: begin
        remain_next = count;
        kept_next   = '0;
      end
      apq_pkg::CMD_PURGE_STEP: begin
        // Pop the head; re-append it behind the kept entries if still patient
        for (int j = 0; j < DEPTH; j++) begin
          slot_next[j] = (head_keep && CW'(j) == wr_pos) ? slot[0] : from_above[j];
        end
        remain_next = CW'(remain - CW'(1));
        kept_next   = CW'(kept + CW'(head_keep));
        if (remain == CW'(1)) begin
          count_next = kept_next;
        end
        res_next.occupancy    = apq_pkg::COUNT_W'(kept_next);
        res_next.purged_count = apq_pkg::COUNT_W'(count - kept_next);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DEPTH; j++) begin
      slot[j] <= slot_next[j];
    end
    remain <= remain_next;
    kept   <= kept_next;
    if (cmd.load_result) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

@@ sv/aging_priority_queue_unit.sv @@
// Insert, remove and age: result registered at the accepting edge, visible in the next cycle.
// Purge: accepted, then scans the stored entries (occupancy before the purge) in turn.
// Throughput: one item per cycle for insert, remove and age unless the result stalls; purge
// holds off items for its scan, as the single head port pops and re-appends one entry each cycle.
// Reset (synchronous, active high): queue empty, no result pending; slot contents undefined.
module aging_priority_queue_unit #(
  parameter int DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  apq_pkg::in_item_t   item,
  output logic                result_valid,
  input  logic                result_stall,
  output apq_pkg::out_item_t  result
);

  // Command and status between the sequencer and the slot array
  apq_pkg::dp_cmd_t    cmd;
  apq_pkg::dp_status_t status;

  // Sequencer: hands each transfer to the datapath, runs the purge scan and
  // owns the output register's valid flag.
  apq_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .action       (item.action),
    .result_stall (result_stall),
    .status       (status),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .cmd          (cmd)
  );

  // Slot array: sorted entries kept in registers, a per-slot compare for the
  // insert position, shifts for insert and remove, and the result register.
  apq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .status (status),
    .result (result)
  );

endmodule

@@ sv/apq_checker.sv @@
module apq_checker #(
  parameter int DEPTH = 8
) (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_stall,
  input apq_pkg::in_item_t   item,
  input logic                result_valid,
  input logic                result_stall,
  input apq_pkg::out_item_t  result
);

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // A refused insert reports a full queue and nothing else
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.dropped |->
      !result.head_valid && result.purged_count == '0 &&
      result.occupancy == apq_pkg::COUNT_W'(DEPTH))
    else $error("drop without a full queue");

  // No head returned means cleared head fields
  a_head_clear: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.head_valid |->
      result.head_payload == '0 && result.head_priority == '0 &&
      result.head_patience == '0)
    else $error("head fields set without a head");

  // Occupancy never exceeds the depth
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (DEPTH > 15) || (result.occupancy <= apq_pkg::COUNT_W'(DEPTH)))
    else $error("occupancy beyond depth");

  // Any transfer other than a purge presents its result on the next cycle
  a_quick_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.action != apq_pkg::ACT_PURGE |=> result_valid)
    else $error("result late for a single-cycle action");

endmodule

bind aging_priority_queue_unit apq_checker #(.DEPTH(DEPTH)) u_apq_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

@@ dv/apq_result_checker.sv @@
module apq_result_checker #(
  parameter int DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_stall,
  input  apq_pkg::in_item_t  item,
  input  logic               result_valid,
  input  logic               result_stall,
  input  apq_pkg::out_item_t result,
  output int                 mismatches,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [apq_pkg::PAYLOAD_W-1:0]     q_pay [DEPTH];
  logic signed [apq_pkg::PRIO_W-1:0] q_pri [DEPTH];
  logic signed [apq_pkg::PRIO_W-1:0] q_pat [DEPTH];
  int                                q_len = 0;
  apq_pkg::out_item_t                pending_outcomes [$];
  int                                errs = 0;

  function automatic logic signed [apq_pkg::PRIO_W-1:0] decay(
    logic signed [apq_pkg::PRIO_W-1:0] v);
    return (v == apq_pkg::PRIO_MIN) ? v : v - 8'sd1;
  endfunction

  // Apply one action to the shadow queue and return the outcome it should produce.
  function automatic apq_pkg::out_item_t apply_queue_action(apq_pkg::in_item_t it);
    apq_pkg::out_item_t                o;
    logic signed [apq_pkg::PRIO_W-1:0] np;
    int                                i;
    int                                pos;
    int                                keep;
    o  = '0;
    np = it.new_priority;
    case (it.action)
      apq_pkg::ACT_INSERT: begin
        if (q_len >= DEPTH) begin
          o.dropped = 1'b1;
        end else begin
          // Entries are sorted, so those at or below the new priority form a prefix.
          pos = 0;
          for (i = 0; i < q_len; i++)
            if (q_pri[i] <= np) pos = i + 1;
          for (i = q_len; i > pos; i--) begin
            q_pay[i] = q_pay[i-1];
            q_pri[i] = q_pri[i-1];
            q_pat[i] = q_pat[i-1];
          end
          q_pay[pos] = it.new_payload;
          q_pri[pos] = it.new_priority;
          q_pat[pos] = it.new_patience;
          q_len++;
        end
      end
      apq_pkg::ACT_REMOVE: begin
        if (q_len > 0) begin
          o.head_valid    = 1'b1;
          o.head_payload  = q_pay[0];
          o.head_priority = q_pri[0];
          o.head_patience = q_pat[0];
          for (i = 1; i < q_len; i++) begin
            q_pay[i-1] = q_pay[i];
            q_pri[i-1] = q_pri[i];
            q_pat[i-1] = q_pat[i];
          end
          q_len--;
        end
      end
      apq_pkg::ACT_AGE: begin
        for (i = 0; i < q_len; i++) begin
          q_pri[i] = decay(q_pri[i]);
          q_pat[i] = decay(q_pat[i]);
        end
      end
      default: begin
        keep = 0;
        for (i = 0; i < q_len; i++) begin
          if (q_pat[i] > 8'sd0) begin
            q_pay[keep] = q_pay[i];
            q_pri[keep] = q_pri[i];
            q_pat[keep] = q_pat[i];
            keep++;
          end
        end
        o.purged_count = apq_pkg::COUNT_W'(q_len - keep);
        q_len = keep;
      end
    endcase
    o.occupancy = apq_pkg::COUNT_W'(q_len);
    return o;
  endfunction

  task automatic check_field(string label, logic signed [31:0] want, logic signed [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      q_len = 0;
      pending_outcomes.delete();
    end else begin
      if (item_valid && !item_stall)
        pending_outcomes.push_back(apply_queue_action(item));
      if (result_valid && !result_stall) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, result);
          errs++;
        end else begin
          apq_pkg::out_item_t want;
          want = pending_outcomes.pop_front();
          check_field("head_valid", 32'(want.head_valid), 32'(result.head_valid));
          check_field("head_payload", 32'(want.head_payload), 32'(result.head_payload));
          check_field("head_priority", 32'(want.head_priority),
                      32'(result.head_priority));
          check_field("head_patience", 32'(want.head_patience),
                      32'(result.head_patience));
          check_field("occupancy", 32'(want.occupancy), 32'(result.occupancy));
          check_field("dropped", 32'(want.dropped), 32'(result.dropped));
          check_field("purged_count", 32'(want.purged_count), 32'(result.purged_count));
        end
      end
    end
    mismatches <= errs;
    pending    <= pending_outcomes.size();
  end

endmodule

@@ dv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 8;
  // Limit on the quiet stretch with no transfer on either channel before giving up.
  localparam int QUIET_LIMIT = 2000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  apq_pkg::in_item_t  item = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  apq_pkg::out_item_t result;

  int mismatches;
  int pending;
  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  bit timed_out = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  aging_priority_queue_unit #(
    .DEPTH(DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  apq_result_checker #(
    .DEPTH(DEPTH)
  ) checker_i (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  // Receiver: stall at random at the current rate, never during reset.
  always @(posedge clk) begin
    result_stall <= !rst && ($urandom_range(99) < recv_gap_pct);
  end

  function automatic apq_pkg::in_item_t make_item(apq_pkg::action_e a, int pay, int pri,
                                                  int pat);
    apq_pkg::in_item_t it;
    it.action       = a;
    it.new_payload  = apq_pkg::PAYLOAD_W'(pay);
    it.new_priority = apq_pkg::PRIO_W'(pri);
    it.new_patience = apq_pkg::PRIO_W'(pat);
    return it;
  endfunction

  // Mostly values near zero so that ties, ageing to expiry and purges happen often;
  // the rest spread over the whole byte or pinned to the extremes.
  function automatic logic [apq_pkg::PRIO_W-1:0] pick_level();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) return apq_pkg::PRIO_W'($urandom_range(8) - 3);
    if (roll < 75) return apq_pkg::PRIO_W'($urandom);
    case ($urandom_range(3))
      0:       return 8'h7F;
      1:       return 8'h7E;
      2:       return 8'h80;
      default: return 8'h81;
    endcase
  endfunction

  // A filling burst favours inserts so the queue reaches full; a draining burst
  // favours removes so it runs dry. Every field is random whatever the action.
  function automatic apq_pkg::in_item_t random_item(bit filling);
    apq_pkg::in_item_t it;
    int                roll;
    roll = $urandom_range(99);
    if (roll < (filling ? 55 : 20))      it.action = apq_pkg::ACT_INSERT;
    else if (roll < (filling ? 75 : 70)) it.action = apq_pkg::ACT_REMOVE;
    else if (roll < 85)                  it.action = apq_pkg::ACT_AGE;
    else                                 it.action = apq_pkg::ACT_PURGE;
    it.new_payload  = apq_pkg::PAYLOAD_W'($urandom);
    it.new_priority = pick_level();
    it.new_patience = pick_level();
    return it;
  endfunction

  // Present one item and hold it until the transfer happens. Valid is only
  // dropped for a gap, so back-to-back items keep it high.
  task automatic offer(apq_pkg::in_item_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
  endtask

  // Stop sending and wait for every outstanding result. The checker's count is
  // registered, so wait for a clock edge before looking at it.
  task automatic hold_until_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic run_directed();
    // Empty queue: nothing to pop, age or purge.
    offer(make_item(apq_pkg::ACT_REMOVE, 'h1234, 3, 3));
    offer(make_item(apq_pkg::ACT_AGE, 'h5678, -3, -3));
    offer(make_item(apq_pkg::ACT_PURGE, 'h9ABC, 0, 0));
    // Fill to the brim with extremes and equal priorities (order of arrival kept).
    offer(make_item(apq_pkg::ACT_INSERT, 'hFFFF, 127, 127));
    offer(make_item(apq_pkg::ACT_INSERT, 'h0000, -128, -128));
    offer(make_item(apq_pkg::ACT_INSERT, 'h0001, 0, 1));
    offer(make_item(apq_pkg::ACT_INSERT, 'h0002, 0, 1));
    offer(make_item(apq_pkg::ACT_INSERT, 'h0003, 0, 1));
    offer(make_item(apq_pkg::ACT_INSERT, 'h0004, 5, 0));
    offer(make_item(apq_pkg::ACT_INSERT, 'h0005, -1, 2));
    offer(make_item(apq_pkg::ACT_INSERT, 'h0006, 0, 1));
    // Full: this one is refused.
    offer(make_item(apq_pkg::ACT_INSERT, 'h0007, -128, 127));
    // Age twice: the minimum entry saturates, the order holds.
    offer(make_item(apq_pkg::ACT_AGE, 'hAAAA, 127, 127));
    offer(make_item(apq_pkg::ACT_AGE, 'h5555, -128, -128));
    // Purge every expired entry, leaving one.
    offer(make_item(apq_pkg::ACT_PURGE, 'h0F0F, 1, 1));
    offer(make_item(apq_pkg::ACT_REMOVE, 'hF0F0, 0, 0));
    offer(make_item(apq_pkg::ACT_REMOVE, 'h0000, 0, 0));
    // Purge with nothing expired.
    offer(make_item(apq_pkg::ACT_INSERT, 'hA5A5, -128, 5));
    offer(make_item(apq_pkg::ACT_PURGE, 'h5A5A, 0, 0));
    offer(make_item(apq_pkg::ACT_REMOVE, 'hFFFF, -1, -1));
  endtask

  task automatic run_random(int count);
    int  left;
    int  burst;
    bit  filling;
    left = count;
    while (left > 0) begin
      filling = 1'($urandom_range(1));
      burst   = $urandom_range(40, 8);
      if (burst > left) burst = left;
      repeat (burst) offer(random_item(filling));
      left -= burst;
    end
  endtask

  task automatic run_stimulus();
    // Slow receiver first.
    send_gap_pct = 27;
    recv_gap_pct = 77;
    run_directed();
    run_random(600);
    hold_until_drained();
    // Then a slow sender.
    send_gap_pct = 77;
    recv_gap_pct = 27;
    run_random(600);
    // Then full rate on both sides.
    send_gap_pct = 0;
    recv_gap_pct = 0;
    run_random(600);
    hold_until_drained();
    // Allow for a purge scan still in flight.
    repeat (DEPTH + 4) @(posedge clk);
  endtask

  task automatic watch_quiet();
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) quiet = 0;
      else quiet++;
    end
    timed_out = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    fork
      run_stimulus();
      watch_quiet();
    join_any
    if (!timed_out && mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ aging_priority_queue_unit.f @@
sv/apq_pkg.sv
sv/apq_ctrl.sv
sv/apq_datapath.sv
sv/aging_priority_queue_unit.sv
sv/apq_checker.sv
dv/apq_result_checker.sv
dv/testbench.sv
